// ===== src/register_vulnerability_tracker_macros.svh =====
// Assertion macros shared by the register vulnerability tracker RTL.
`ifndef REGISTER_VULNERABILITY_TRACKER_MACROS_SVH
`define REGISTER_VULNERABILITY_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvt assertion failed");

// Next-cycle implication, checked outside reset.
`define RVT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvt assertion failed");

`endif

// ===== src/rvt_pkg.sv =====
// Shared constants and types of the register vulnerability tracker.
`timescale 1ns / 1ps
package rvt_pkg;

  localparam int NUM_REGS    = 16;
  localparam int MAX_SRC     = 4;
  localparam int MAX_DST     = 2;
  localparam int COUNT_WIDTH = 32;

  localparam int SRC_FIELDS  = 4;
  localparam int DST_FIELDS  = 2;
  localparam int IDX_W       = 8;
  localparam int REG_W       = $clog2(NUM_REGS);
  localparam int SUM_W       = COUNT_WIDTH + 4;
  localparam int GROUP_SIZE  = 8;
  localparam int GROUPS      = (NUM_REGS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PART_W      = COUNT_WIDTH + 3;
  localparam int ACC_W       = COUNT_WIDTH + 7;
  localparam int DEN_W       = COUNT_WIDTH + 7;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = $clog2(FRAC_BITS);
  localparam int PVF_W       = 17;
  localparam int TOTAL_W     = 32;
  localparam int INTERVAL_W  = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [PVF_W-1:0]      Q_ONE          = 17'h10000;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [0:0] {
    REG_REPORT_INTERVAL = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]                         src_count;
    logic [SRC_FIELDS-1:0][IDX_W-1:0]   src_reg;
    logic [1:0]                         dst_count;
    logic [DST_FIELDS-1:0][IDX_W-1:0]   dst_reg;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    count_t           total;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PVF_W-1:0] frac;
  } div_stat_t;

endpackage

// ===== src/register_vulnerability_tracker.sv =====
// Top level: register lanes, merge tree, ratio divider and report output.
// Non-reporting instruction: one transfer per cycle while no report is pending, in_ready stays high.
// Reporting instruction: result passes the lane, two merge stages, divider load, 16
// divider steps and output load; the steps are skipped when the ratio saturates at one,
// and the output waits while the output register is held; in_ready is low until the report loads.
// Synchronous active-low reset clears counters, lanes and sum; report_interval returns to 1000.
`timescale 1ns / 1ps
`include "register_vulnerability_tracker_macros.svh"
module register_vulnerability_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_src_count,
  input  logic [7:0]                   in_src_reg_0,
  input  logic [7:0]                   in_src_reg_1,
  input  logic [7:0]                   in_src_reg_2,
  input  logic [7:0]                   in_src_reg_3,
  input  logic [1:0]                   in_dst_count,
  input  logic [7:0]                   in_dst_reg_0,
  input  logic [7:0]                   in_dst_reg_1,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  out_retired_total,
  output logic [16:0]                  out_pvf_fraction,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rvt_pkg::ADDR_W-1:0]   paddr,
  input  logic [rvt_pkg::DATA_W-1:0]   pwdata,
  output logic [rvt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  rvt_pkg::item_t     item;
  rvt_pkg::count_t    total_r, total_nxt, snap_r;
  rvt_pkg::count_t    lane_delta [rvt_pkg::NUM_REGS];
  rvt_pkg::div_req_t  div_req;
  rvt_pkg::div_stat_t div_stat;
  logic [rvt_pkg::INTERVAL_W-1:0] interval_r, left_r, left_nxt;
  logic [rvt_pkg::SUM_W-1:0]      merge_sum;
  logic [rvt_pkg::TOTAL_W-1:0]    out_total_r;
  logic [rvt_pkg::PVF_W-1:0]      out_pvf_r;
  logic accept, report_hit, cfg_wr, merge_rpt, take;
  logic busy_r, busy_nxt, rpt_a_r, out_valid_r, out_valid_nxt;

  assign item.src_count  = in_src_count;
  assign item.src_reg[0] = in_src_reg_0;
  assign item.src_reg[1] = in_src_reg_1;
  assign item.src_reg[2] = in_src_reg_2;
  assign item.src_reg[3] = in_src_reg_3;
  assign item.dst_count  = in_dst_count;
  assign item.dst_reg[0] = in_dst_reg_0;
  assign item.dst_reg[1] = in_dst_reg_1;

  assign in_ready   = !busy_r;
  assign accept     = in_valid && in_ready;
  assign report_hit = (left_r <= rvt_pkg::INTERVAL_W'(1));
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == rvt_pkg::REG_REPORT_INTERVAL);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == rvt_pkg::REG_REPORT_INTERVAL) ? interval_r : '0;

  always_comb begin
    total_nxt = (total_r != {rvt_pkg::COUNT_WIDTH{1'b1}}) ? total_r + 1'b1 : total_r;
    left_nxt  = left_r;
    if (cfg_wr) begin
      left_nxt = pwdata;
    end else if (accept) begin
      left_nxt = report_hit ? interval_r : left_r - 1'b1;
    end
    take     = div_stat.done && (!out_valid_r || out_ready);
    busy_nxt = busy_r;
    if (accept && report_hit) busy_nxt = 1'b1;
    else if (take) busy_nxt = 1'b0;
    out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= rvt_pkg::INTERVAL_RESET;
      left_r      <= rvt_pkg::INTERVAL_RESET;
      total_r     <= '0;
      busy_r      <= 1'b0;
      rpt_a_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) interval_r <= pwdata;
      left_r      <= left_nxt;
      if (accept) total_r <= total_nxt;
      busy_r      <= busy_nxt;
      rpt_a_r     <= accept && report_hit;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && report_hit) snap_r <= total_nxt;
    if (take) begin
      out_total_r <= rvt_pkg::TOTAL_W'(snap_r);
      out_pvf_r   <= div_stat.frac;
    end
  end

  for (genvar l = 0; l < rvt_pkg::NUM_REGS; l++) begin : g_lane
    rvt_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .lane_idx   (rvt_pkg::REG_W'(l)),
      .accept     (accept),
      .item       (item),
      .inst_total (total_r),
      .delta      (lane_delta[l])
    );
  end

  rvt_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .delta   (lane_delta),
    .rpt_in  (rpt_a_r),
    .sum     (merge_sum),
    .rpt_out (merge_rpt)
  );

  assign div_req.start = merge_rpt;
  assign div_req.num   = merge_sum;
  assign div_req.total = snap_r;

  rvt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .take  (take),
    .stat  (div_stat)
  );

  assign out_valid         = out_valid_r;
  assign out_retired_total = out_total_r;
  assign out_pvf_fraction  = out_pvf_r;

  `RVT_ASSERT_NXT(a_report_blocks_input, accept && report_hit, !in_ready)
  `RVT_ASSERT_IMP(a_div_only_when_busy, div_stat.busy, busy_r)
  `RVT_ASSERT_IMP(a_pvf_bounded, out_valid_r, out_pvf_r <= rvt_pkg::Q_ONE)
  `RVT_ASSERT_NXT(a_take_loads_output, take, out_valid_r && !busy_r)

endmodule

// ===== src/rvt_lane.sv =====
// One register lane: liveness counter, last touch and per-transfer increment.
`timescale 1ns / 1ps
module rvt_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rvt_pkg::REG_W-1:0] lane_idx,
  input  logic                      accept,
  input  rvt_pkg::item_t            item,
  input  rvt_pkg::count_t           inst_total,
  output rvt_pkg::count_t           delta
);

  rvt_pkg::count_t count_r, count_nxt;
  rvt_pkg::count_t touch_r;
  rvt_pkg::count_t delta_r;
  rvt_pkg::count_t gap, room, inc;
  logic [2:0] ns;
  logic [1:0] nd;
  logic [rvt_pkg::IDX_W-1:0] my_idx;
  logic src_hit, dst_hit;

  always_comb begin
    my_idx = {{(rvt_pkg::IDX_W - rvt_pkg::REG_W){1'b0}}, lane_idx};
    ns = (item.src_count > 3'(rvt_pkg::MAX_SRC)) ? 3'(rvt_pkg::MAX_SRC) : item.src_count;
    nd = (item.dst_count > 2'(rvt_pkg::MAX_DST)) ? 2'(rvt_pkg::MAX_DST) : item.dst_count;
    src_hit = 1'b0;
    for (int i = 0; i < rvt_pkg::SRC_FIELDS; i++) begin
      if ((3'(i) < ns) && (item.src_reg[i] == my_idx)) src_hit = 1'b1;
    end
    dst_hit = 1'b0;
    for (int j = 0; j < rvt_pkg::DST_FIELDS; j++) begin
      if ((2'(j) < nd) && (item.dst_reg[j] == my_idx)) dst_hit = 1'b1;
    end
    // repeated reads in one instruction set src_hit only once, so one increment suffices
    gap       = inst_total - touch_r;
    room      = {rvt_pkg::COUNT_WIDTH{1'b1}} - count_r;
    inc       = (gap > room) ? room : gap;
    count_nxt = count_r + inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      touch_r <= '0;
      delta_r <= '0;
    end else begin
      if (accept && src_hit) count_r <= count_nxt;
      if (accept && (src_hit || dst_hit)) touch_r <= inst_total;
      delta_r <= (accept && src_hit) ? inc : '0;
    end
  end

  assign delta = delta_r;

endmodule

// ===== src/rvt_merge.sv =====
// Merge stage: registered adder tree over lane increments into the saturating sum.
`timescale 1ns / 1ps
module rvt_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rvt_pkg::count_t            delta [rvt_pkg::NUM_REGS],
  input  logic                       rpt_in,
  output logic [rvt_pkg::SUM_W-1:0]  sum,
  output logic                       rpt_out
);

  logic [rvt_pkg::PART_W-1:0] part_r   [rvt_pkg::GROUPS];
  logic [rvt_pkg::PART_W-1:0] part_nxt [rvt_pkg::GROUPS];
  logic [rvt_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [rvt_pkg::ACC_W-1:0]  acc;
  logic rpt_b_r, rpt_c_r;

  always_comb begin
    for (int g = 0; g < rvt_pkg::GROUPS; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < rvt_pkg::GROUP_SIZE; k++) begin
        if (g * rvt_pkg::GROUP_SIZE + k < rvt_pkg::NUM_REGS) begin
          part_nxt[g] = part_nxt[g] +
                        rvt_pkg::PART_W'(delta[g * rvt_pkg::GROUP_SIZE + k]);
        end
      end
    end
    acc = rvt_pkg::ACC_W'(sum_r);
    for (int g = 0; g < rvt_pkg::GROUPS; g++) begin
      acc = acc + rvt_pkg::ACC_W'(part_r[g]);
    end
    sum_nxt = (acc > rvt_pkg::ACC_W'({rvt_pkg::SUM_W{1'b1}})) ?
              {rvt_pkg::SUM_W{1'b1}} : acc[rvt_pkg::SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < rvt_pkg::GROUPS; g++) part_r[g] <= '0;
      sum_r   <= '0;
      rpt_b_r <= 1'b0;
      rpt_c_r <= 1'b0;
    end else begin
      for (int g = 0; g < rvt_pkg::GROUPS; g++) part_r[g] <= part_nxt[g];
      sum_r   <= sum_nxt;
      rpt_b_r <= rpt_in;
      rpt_c_r <= rpt_b_r;
    end
  end

  assign sum     = sum_r;
  assign rpt_out = rpt_c_r;

endmodule

// ===== src/rvt_div.sv =====
// Restoring divider: one quotient bit per cycle for the Q1.16 ratio.
`timescale 1ns / 1ps
module rvt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rvt_pkg::div_req_t  req,
  input  logic               take,
  output rvt_pkg::div_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [rvt_pkg::DEN_W-1:0]  den_r, den_nxt, den_calc, num_ext;
  logic [rvt_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [rvt_pkg::DEN_W:0]    rem2;
  logic [rvt_pkg::PVF_W-1:0]  frac_r, frac_nxt;
  logic [rvt_pkg::STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    den_calc  = rvt_pkg::DEN_W'(req.total) * rvt_pkg::DEN_W'(rvt_pkg::NUM_REGS);
    num_ext   = rvt_pkg::DEN_W'(req.num);
    rem2      = {rem_r, 1'b0};
    state_nxt = state_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    frac_nxt  = frac_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          den_nxt = den_calc;
          if ((den_calc == '0) || (num_ext >= den_calc)) begin
            frac_nxt  = rvt_pkg::Q_ONE;
            state_nxt = S_DONE;
          end else begin
            rem_nxt   = num_ext;
            frac_nxt  = '0;
            step_nxt  = '0;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt  = rvt_pkg::DEN_W'(rem2 - {1'b0, den_r});
          frac_nxt = {frac_r[rvt_pkg::PVF_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem2[rvt_pkg::DEN_W-1:0];
          frac_nxt = {frac_r[rvt_pkg::PVF_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == rvt_pkg::STEP_W'(rvt_pkg::FRAC_BITS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    frac_r <= frac_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.frac = frac_r;

endmodule
